// File: sv/cnlc_pkg.sv
`default_nettype none

package cnlc_pkg;

  // Input width and the decimal form used by the converter
  localparam int NumW         = 54;
  localparam int DigitsN      = 17;
  localparam int BcdW         = 4 * DigitsN;
  localparam int BitsPerStage = 6;
  localparam int DabbleStages = NumW / BitsPerStage;
  localparam int LuhnDigits   = 16;
  localparam int SumW         = 8;

  // Class codes on the result port
  typedef enum logic [1:0] {
    CLS_INVALID = 2'd0,
    CLS_VI      = 2'd1,
    CLS_MC      = 2'd2,
    CLS_AE      = 2'd3
  } card_class_e;

  // Prefix/length ranges
  localparam logic [NumW-1:0] Vi16Lo = 54'd4000000000000000;
  localparam logic [NumW-1:0] Vi16Hi = 54'd4999999999999999;
  localparam logic [NumW-1:0] McLo   = 54'd5100000000000000;
  localparam logic [NumW-1:0] McHi   = 54'd5599999999999999;
  localparam logic [NumW-1:0] Vi13Lo = 54'd4000000000000;
  localparam logic [NumW-1:0] Vi13Hi = 54'd4999999999999;
  localparam logic [NumW-1:0] Ae34Lo = 54'd340000000000000;
  localparam logic [NumW-1:0] Ae34Hi = 54'd349999999999999;
  localparam logic [NumW-1:0] Ae37Lo = 54'd370000000000000;
  localparam logic [NumW-1:0] Ae37Hi = 54'd379999999999999;

  // Beat moving through the converter stages
  typedef struct packed {
    logic [NumW-1:0] bin;
    logic [BcdW-1:0] bcd;
    card_class_e     kind;
  } dabble_t;

  // Beat after the digit sum
  typedef struct packed {
    logic [SumW-1:0] sum;
    card_class_e     kind;
  } luhn_t;

  function automatic logic in_range(logic [NumW-1:0] v, logic [NumW-1:0] lo,
                                    logic [NumW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Candidate class from length and prefix, before the Luhn check
  function automatic card_class_e classify(logic [NumW-1:0] v);
    card_class_e k;
    priority if (in_range(v, Vi16Lo, Vi16Hi)) k = CLS_VI;
    else if (in_range(v, McLo, McHi))         k = CLS_MC;
    else if (in_range(v, Vi13Lo, Vi13Hi))     k = CLS_VI;
    else if (in_range(v, Ae34Lo, Ae34Hi) || in_range(v, Ae37Lo, Ae37Hi)) k = CLS_AE;
    else                                      k = CLS_INVALID;
    return k;
  endfunction

  // Add-3 correction of one BCD digit
  function automatic logic [3:0] add3(logic [3:0] d);
    return (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

  // Luhn weight of one digit; odd positions are doubled and folded
  function automatic logic [3:0] luhn_digit(logic [3:0] d, logic odd);
    logic [4:0] dd;
    dd = {d, 1'b0};
    if (!odd) return d;
    return (dd > 5'd9) ? 4'(dd - 5'd9) : dd[3:0];
  endfunction

  // Sum is at most 144: compare against the multiples of ten
  function automatic logic sum_ok(logic [SumW-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 15; k++) begin
      if (s == SumW'(k * 10)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: sv/cnlc_dabble_stage.sv
`default_nettype none

module cnlc_dabble_stage import cnlc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire dabble_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output dabble_t      data_o
);

  logic    valid_q;
  dabble_t data_q, data_d;
  logic [NumW-1:0] bin;
  logic [BcdW-1:0] bcd;

  // Shift-add-3 over one slice of input bits
  always_comb begin
    bin = data_i.bin;
    bcd = data_i.bcd;
    for (int s = 0; s < BitsPerStage; s++) begin
      for (int d = 0; d < DigitsN; d++) begin
        bcd[4*d +: 4] = add3(bcd[4*d +: 4]);
      end
      bcd = {bcd[BcdW-2:0], bin[NumW-1]};
      bin = {bin[NumW-2:0], 1'b0};
    end
    data_d.bin  = bin;
    data_d.bcd  = bcd;
    data_d.kind = data_i.kind;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/cnlc_luhn_stage.sv
`default_nettype none

module cnlc_luhn_stage import cnlc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire dabble_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output luhn_t        data_o
);

  logic       valid_q;
  luhn_t      data_q, data_d;
  logic [3:0] w  [LuhnDigits];
  logic [4:0] l1 [LuhnDigits/2];
  logic [5:0] l2 [LuhnDigits/4];
  logic [6:0] l3 [LuhnDigits/8];

  // Weighted digits and a balanced adder tree
  always_comb begin
    for (int p = 0; p < LuhnDigits; p++) begin
      w[p] = luhn_digit(data_i.bcd[4*p +: 4], p[0]);
    end
    for (int i = 0; i < LuhnDigits/2; i++) begin
      l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    end
    for (int i = 0; i < LuhnDigits/4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < LuhnDigits/8; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    data_d.sum  = {1'b0, l3[0]} + {1'b0, l3[1]};
    data_d.kind = data_i.kind;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/card_number_luhn_classifier_core.sv
`default_nettype none
// Throughput: one beat per cycle while out_ready_i is high; the binary-to-decimal
//   converter is a chain of 9 stages of 6 shift-add-3 steps each, followed by a
//   digit-sum stage and an output register.
// Reset: rst_ni clears the valid bit of every stage; data registers are not reset.
module card_number_luhn_classifier_core import cnlc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [NumW-1:0] card_number_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           card_class_o
);

  logic    vld   [DabbleStages+1];
  logic    rdy   [DabbleStages+1];
  dabble_t dab   [DabbleStages+1];
  logic    l_vld, l_rdy;
  luhn_t   l_dat;
  logic    s0_valid_q, out_valid_q;
  dabble_t s0_q;
  card_class_e class_q, class_d;

  // Entry stage: range classification, clear BCD field
  assign in_ready_o = !s0_valid_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_q.bin  <= card_number_i;
      s0_q.bcd  <= '0;
      s0_q.kind <= classify(card_number_i);
    end
  end

  assign vld[0] = s0_valid_q;
  assign dab[0] = s0_q;

  // Binary-to-decimal pipeline
  for (genvar g = 0; g < DabbleStages; g++) begin : g_dab
    cnlc_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .data_i  (dab[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .data_o  (dab[g+1])
    );
  end

  // Luhn digit sum
  cnlc_luhn_stage u_luhn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[DabbleStages]),
    .ready_o (rdy[DabbleStages]),
    .data_i  (dab[DabbleStages]),
    .valid_o (l_vld),
    .ready_i (l_rdy),
    .data_o  (l_dat)
  );

  // Output register: mod-10 check gates the class
  assign class_d = sum_ok(l_dat.sum) ? l_dat.kind : CLS_INVALID;
  assign l_rdy   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (l_rdy) begin
      out_valid_q <= l_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_rdy && l_vld) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign card_class_o = class_q;

endmodule

`default_nettype wire
